FILE: hdl/led_blink_request_sequencer_top_assert.svh
// ============================================================================
// LED blink request sequencer - assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ============================================================================
`ifndef LED_BLINK_REQUEST_SEQUENCER_TOP_ASSERT_SVH
`define LED_BLINK_REQUEST_SEQUENCER_TOP_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define LBRS_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define LBRS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hdl/lbrs_pkg.sv
// ============================================================================
// LED blink request sequencer - package
// Shared types, codes, request mapping and color table.
// ============================================================================
package lbrs_pkg;

    localparam int LBRS_QUEUE_DEPTH = 16;

    // command codes
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_PEER   = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    // peer state codes
    localparam logic [2:0] PEER_DISCONNECTED = 3'd0;
    localparam logic [2:0] PEER_CONNECTED    = 3'd1;
    localparam logic [2:0] PEER_SECURED      = 3'd2;
    localparam logic [2:0] PEER_FAILED       = 3'd3;

    // config register indexes
    localparam logic [1:0] REG_SHORT  = 2'd0;
    localparam logic [1:0] REG_MEDIUM = 2'd1;
    localparam logic [1:0] REG_LONG   = 2'd2;

    localparam logic [15:0] SHORT_RESET  = 16'd100;
    localparam logic [15:0] MEDIUM_RESET = 16'd300;
    localparam logic [15:0] LONG_RESET   = 16'd1000;

    typedef logic [2:0] t_color;
    localparam t_color COL_RED    = 3'd0;
    localparam t_color COL_GREEN  = 3'd1;
    localparam t_color COL_BLUE   = 3'd2;
    localparam t_color COL_ORANGE = 3'd3;
    localparam t_color COL_BLACK  = 3'd4;

    typedef logic [1:0] t_dur;
    localparam t_dur DUR_SHORT  = 2'd0;
    localparam t_dur DUR_MEDIUM = 2'd1;
    localparam t_dur DUR_LONG   = 2'd2;
    localparam t_dur DUR_NONE   = 2'd3;

    localparam logic [7:0] LVL_FULL   = 8'd25;
    localparam logic [7:0] LVL_ORANGE = 8'd17;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ON   = 2'd1,
        PH_OFF  = 2'd2
    } t_phase;

    // queue entry, 10 bits: color [2:0], count [6:3], class [8:7], background [9]
    typedef struct packed {
        logic       bg;
        t_dur       dur;
        logic [3:0] count;
        t_color     color;
    } t_request;

    localparam int REQ_W = $bits(t_request);

    typedef struct packed {
        logic [15:0] short_ms;
        logic [15:0] medium_ms;
        logic [15:0] long_ms;
    } t_blink_cfg;

    typedef struct packed {
        logic     push;
        logic     pop;
        t_request wdata;
    } t_fifo_cmd;

    typedef struct packed {
        logic     empty;
        logic     full;
        t_request head;
    } t_fifo_stat;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgb;

    function automatic t_request make_request(input t_color c, input logic [3:0] n,
                                              input t_dur d, input logic bg);
        t_request r;
        r.color = c;
        r.count = n;
        r.dur   = d;
        r.bg    = bg;
        return r;
    endfunction

    function automatic t_request event_request(input logic [1:0] cmd,
                                               input logic [2:0] peer,
                                               input logic search);
        t_request r;
        if (cmd == CMD_SEARCH) begin
            r = search ? make_request(COL_BLUE, 4'd10, DUR_LONG, 1'b1)
                       : make_request(COL_BLACK, 4'd0, DUR_NONE, 1'b1);
        end else begin
            case (peer)
                PEER_DISCONNECTED: r = make_request(COL_RED, 4'd2, DUR_SHORT, 1'b0);
                PEER_CONNECTED:    r = make_request(COL_ORANGE, 4'd2, DUR_MEDIUM, 1'b0);
                PEER_SECURED:      r = make_request(COL_GREEN, 4'd2, DUR_MEDIUM, 1'b0);
                PEER_FAILED:       r = make_request(COL_RED, 4'd5, DUR_MEDIUM, 1'b0);
                default:           r = make_request(COL_BLACK, 4'd0, DUR_NONE, 1'b0);
            endcase
        end
        return r;
    endfunction

    function automatic logic [15:0] duration_of(input t_blink_cfg cfg, input t_dur d);
        logic [15:0] v;
        case (d)
            DUR_SHORT:  v = cfg.short_ms;
            DUR_MEDIUM: v = cfg.medium_ms;
            DUR_LONG:   v = cfg.long_ms;
            default:    v = 16'd0;
        endcase
        return v;
    endfunction

    function automatic t_rgb color_rgb(input t_color c);
        t_rgb v;
        v = '0;
        case (c)
            COL_RED:    v.red = LVL_FULL;
            COL_GREEN:  v.green = LVL_FULL;
            COL_BLUE:   v.blue = LVL_FULL;
            COL_ORANGE: begin
                v.red   = LVL_FULL;
                v.green = LVL_ORANGE;
            end
            default:    v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/lbrs_ram.sv
// ============================================================================
// LBRS generic RAM
// One write port, one read port, registered read (old data on collision).
// ============================================================================
module lbrs_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/lbrs_fifo.sv
// ============================================================================
// LBRS request queue
// Show-ahead FIFO on the generic RAM; head entry valid whenever not empty.
// ============================================================================
module lbrs_fifo
    import lbrs_pkg::*;
#(
    parameter int DEPTH = LBRS_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_fifo_cmd  i_cmd,
    output t_fifo_stat o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(DEPTH);

    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [FW-1:0]    r_fill, n_fill;
    logic             r_byp_hit;
    logic [REQ_W-1:0] r_byp_data;
    logic [REQ_W-1:0] w_ram_q;

    // read address tracks the pointer after this cycle's pop
    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_fill   = r_fill;
        if (i_cmd.pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_cmd.push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_cmd.push && !i_cmd.pop) begin
            n_fill = r_fill + 1'b1;
        end else if (i_cmd.pop && !i_cmd.push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    lbrs_ram #(
        .WIDTH (REQ_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_cmd.wdata),
        .i_raddr (n_rd_ptr),
        .o_rdata (w_ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr  <= '0;
            r_wr_ptr  <= '0;
            r_fill    <= '0;
            r_byp_hit <= 1'b0;
        end else begin
            r_rd_ptr  <= n_rd_ptr;
            r_wr_ptr  <= n_wr_ptr;
            r_fill    <= n_fill;
            r_byp_hit <= i_cmd.push && (r_wr_ptr == n_rd_ptr);
        end
    end

    // write-to-read forward covers the RAM's old-data collision
    always_ff @(posedge i_clk) begin
        r_byp_data <= i_cmd.wdata;
    end

    assign o_stat.empty = (r_fill == '0);
    assign o_stat.full  = (r_fill == FILL_MAX);
    assign o_stat.head  = r_byp_hit ? t_request'(r_byp_data) : t_request'(w_ram_q);

`include "led_blink_request_sequencer_top_assert.svh"

    `LBRS_ASSERT_ALWAYS(a_fill_bound, r_fill <= FILL_MAX, "fifo fill above depth")
    `LBRS_ASSERT_IMPLY(a_no_pop_empty, i_cmd.pop, r_fill != '0, "pop from empty fifo")
    `LBRS_ASSERT_IMPLY(a_no_push_full, i_cmd.push, r_fill != FILL_MAX, "push into full fifo")

endmodule

FILE: hdl/lbrs_blink.sv
// ============================================================================
// LBRS blink sequencer
// Event-to-request mapping, tick-driven blink phases and run state.
// ============================================================================
module lbrs_blink
    import lbrs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_go,
    input  logic [1:0] i_command,
    input  logic [2:0] i_peer_state,
    input  logic       i_search_active,
    input  t_blink_cfg i_cfg,
    input  t_fifo_stat i_fifo,
    output t_fifo_cmd  o_fifo,
    output t_color     o_shown,
    output logic       o_dropped
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_timer, n_timer;
    logic [3:0]  r_left, n_left;
    t_color      r_color, n_color;
    t_dur        r_dclass, n_dclass;
    logic        r_bg, n_bg;

    logic        w_is_tick, w_is_event;
    logic        w_pop_ok, w_bound;
    logic [15:0] w_dur_cur, w_half;
    t_color      w_b_color;
    t_dur        w_b_dclass;
    logic [3:0]  w_b_left;
    logic        w_b_bg;

    assign w_is_tick  = (i_command == CMD_TICK);
    assign w_is_event = (i_command == CMD_PEER) || (i_command == CMD_SEARCH);
    assign w_dur_cur  = duration_of(i_cfg, r_dclass);
    assign w_half     = {1'b0, w_dur_cur[15:1]};

    // run state as a blink boundary would leave it
    assign w_pop_ok   = ((r_left == '0) || r_bg) && !i_fifo.empty;
    assign w_b_color  = w_pop_ok ? i_fifo.head.color : r_color;
    assign w_b_dclass = w_pop_ok ? i_fifo.head.dur : r_dclass;
    assign w_b_left   = w_pop_ok ? i_fifo.head.count : r_left;
    assign w_b_bg     = w_pop_ok ? i_fifo.head.bg : r_bg;

    always_comb begin
        n_phase  = r_phase;
        n_timer  = r_timer;
        n_left   = r_left;
        n_color  = r_color;
        n_dclass = r_dclass;
        n_bg     = r_bg;
        w_bound  = 1'b0;
        if (i_go && w_is_tick) begin
            case (r_phase)
                PH_ON: begin
                    if (r_timer > 16'd1) begin
                        n_timer = r_timer - 16'd1;
                    end else if (w_half != '0) begin
                        n_phase = PH_OFF;
                        n_timer = w_half;
                    end else begin
                        w_bound = 1'b1;
                    end
                end
                PH_OFF: begin
                    if (r_timer > 16'd1) begin
                        n_timer = r_timer - 16'd1;
                    end else begin
                        w_bound = 1'b1;
                    end
                end
                default: w_bound = 1'b1;
            endcase
            if (w_bound) begin
                n_color  = w_b_color;
                n_dclass = w_b_dclass;
                n_bg     = w_b_bg;
                if (w_b_left != '0) begin
                    n_left  = w_b_left - 4'd1;
                    n_phase = PH_ON;
                    n_timer = duration_of(i_cfg, w_b_dclass);
                end else begin
                    n_left  = '0;
                    n_phase = PH_IDLE;
                    n_timer = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_timer  <= '0;
            r_left   <= '0;
            r_color  <= COL_BLACK;
            r_dclass <= DUR_SHORT;
            r_bg     <= 1'b1;
        end else begin
            r_phase  <= n_phase;
            r_timer  <= n_timer;
            r_left   <= n_left;
            r_color  <= n_color;
            r_dclass <= n_dclass;
            r_bg     <= n_bg;
        end
    end

    assign o_fifo.pop   = w_bound && w_pop_ok;
    assign o_fifo.push  = i_go && w_is_event && !i_fifo.full;
    assign o_fifo.wdata = event_request(i_command, i_peer_state, i_search_active);
    assign o_dropped    = w_is_event && i_fifo.full;
    assign o_shown      = (n_phase == PH_ON) ? n_color : COL_BLACK;

`include "led_blink_request_sequencer_top_assert.svh"

    `LBRS_ASSERT_IMPLY(a_off_timer, r_phase == PH_OFF, r_timer != '0, "off phase with zero timer")
    `LBRS_ASSERT_IMPLY(a_idle_spent, r_phase == PH_IDLE, r_left == '0, "idle with blinks left")
    `LBRS_ASSERT_IMPLY(a_pop_tick, o_fifo.pop, i_go && w_is_tick, "pop outside a tick")

endmodule

FILE: hdl/led_blink_request_sequencer_top.sv
// ============================================================================
// LED blink request sequencer - top level
// Event queue and tick-driven RGB blink sequencing behind stream ports.
// ============================================================================
// Usage:
//   Input stream (i_s_*): one beat per event or 1 ms tick; i_s_tuser holds
//   the command. Peer and search events push a blink request into a
//   QUEUE_DEPTH-entry queue; a tick steps the blink timer and, at a blink
//   boundary, may take the next request.
//   Output stream (o_m_*): exactly one beat per input beat, carrying the LED
//   color after that step and a flag for a request lost to a full queue.
//   Config port: i_cfg_we writes register i_cfg_idx (0 short, 1 medium,
//   2 long on time, in ticks); write only while the block is idle.
//   Path: accepted beat -> input register -> result register -> o_m_tvalid.
//   Throughput: one beat per cycle while i_m_tready holds, set by the single
//   compute stage between the two registers; the queue RAM's registered
//   read is hidden by a prefetched head entry.
//   Stall: if the result register is held, the input register keeps its
//   beat and o_s_tready drops only once both are occupied.
//   Reset: i_rst_n synchronous, active low; queue empties, LED idle/black,
//   on times return to 100/300/1000 ticks. Queue RAM needs no clearing.
// ============================================================================
module led_blink_request_sequencer_top
    import lbrs_pkg::*;
#(
    parameter int QUEUE_DEPTH = LBRS_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [2:0] peer_state, [3] search_active,
                                     // [7:4] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] command
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [7:0] led_red, [15:8] led_green,
                                     // [23:16] led_blue, [24] request_dropped,
                                     // [31:25] zero
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    // input register
    logic       r_in_valid;
    logic [1:0] r_command;
    logic [2:0] r_peer_state;
    logic       r_search_active;

    // result register
    logic       r_out_valid;
    t_rgb       r_rgb;
    logic       r_dropped;

    t_blink_cfg r_cfg;

    logic       w_adv;   // result register can take a new beat
    logic       w_go;    // the held input beat is processed this cycle
    t_fifo_cmd  w_fifo_cmd;
    t_fifo_stat w_fifo_stat;
    t_color     w_shown;
    logic       w_dropped;

    assign w_adv      = !r_out_valid || i_m_tready;
    assign w_go       = r_in_valid && w_adv;
    assign o_s_tready = !r_in_valid || w_adv;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_ms  <= SHORT_RESET;
            r_cfg.medium_ms <= MEDIUM_RESET;
            r_cfg.long_ms   <= LONG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SHORT:  r_cfg.short_ms  <= i_cfg_data;
                REG_MEDIUM: r_cfg.medium_ms <= i_cfg_data;
                REG_LONG:   r_cfg.long_ms   <= i_cfg_data;
                default:    r_cfg <= r_cfg;
            endcase
        end
    end

    // input beat capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_command       <= i_s_tuser;
            r_peer_state    <= i_s_tdata[2:0];
            r_search_active <= i_s_tdata[3];
        end
    end

    lbrs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_fifo_cmd),
        .o_stat  (w_fifo_stat)
    );

    lbrs_blink u_blink (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_go            (w_go),
        .i_command       (r_command),
        .i_peer_state    (r_peer_state),
        .i_search_active (r_search_active),
        .i_cfg           (r_cfg),
        .i_fifo          (w_fifo_stat),
        .o_fifo          (w_fifo_cmd),
        .o_shown         (w_shown),
        .o_dropped       (w_dropped)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_rgb     <= color_rgb(w_shown);
            r_dropped <= w_dropped;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_dropped, r_rgb.blue, r_rgb.green, r_rgb.red};

endmodule

FILE: sim/led_blink_request_sequencer_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// LED blink request sequencer - testbench
// Sends link, search and tick beats, keeps its own model of the request
// queue and blink timer, and checks each LED beat against it or a typed-in
// result. A short table covers reset, the special cases and a full queue.
// Random phases follow, with on times from zero to the maximum.
// ============================================================================
module led_blink_request_sequencer_top_tb;
    import lbrs_pkg::*;

    localparam int          CYCLE_LIMIT = 300000;
    localparam int          PHASES      = 6;
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;   // no-op command
    localparam logic [2:0]  PEER_OTHER  = 3'd4;   // first of the "other" states

    // one LED beat: fields from o_m_tdata[24:0], highest first
    typedef struct packed {
        logic       dropped;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_led_beat;

    localparam t_led_beat LED_DARK     = 25'd0;
    localparam t_led_beat LED_RED_ON   = {1'b0, 8'd0, 8'd0, LVL_FULL};
    localparam t_led_beat LED_RED_DROP = {1'b1, 8'd0, 8'd0, LVL_FULL};

    // directed row: a beat, plus a typed-in result where one is obvious
    typedef struct {
        logic [1:0] cmd;
        logic [2:0] peer;
        logic       srch;
        bit         typed;
        t_led_beat  want;
    } t_plan_row;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;    // [2:0] peer_state, [3] search_active
    logic [1:0]  i_s_tuser;    // [1:0] command
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b1;
    logic [31:0] o_m_tdata;    // [7:0] red, [15:8] green, [23:16] blue, [24] dropped
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    led_blink_request_sequencer_top #(
        .QUEUE_DEPTH(LBRS_QUEUE_DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Scoreboard state
    // ------------------------------------------------------------------
    t_led_beat   led_expected[$];     // LED beats still owed by the DUT
    int          fail_count      = 0;
    int          beats_sent      = 0;
    int          beats_checked   = 0;
    int          drops_predicted = 0;
    int          lit_predicted   = 0;
    int          cycle_count     = 0;
    bit          quiet           = 1'b0;   // no idling on either side
    int          rx_hold         = 0;

    // ------------------------------------------------------------------
    // Blink model: on-time registers, request queue, run and timer
    // ------------------------------------------------------------------
    logic [15:0] on_short, on_medium, on_long;
    t_request    pending_requests[$];
    t_phase      led_phase;
    logic [15:0] led_timer;
    logic [3:0]  run_left;
    t_color      run_col;
    t_dur        run_cls;
    logic        run_bg;

    function automatic logic [15:0] on_time(input t_dur cls);
        case (cls)
            DUR_SHORT:  return on_short;
            DUR_MEDIUM: return on_medium;
            DUR_LONG:   return on_long;
            default:    return 16'd0;
        endcase
    endfunction

    function automatic t_request request_for(input logic [1:0] cmd, input logic [2:0] peer,
                                             input logic srch);
        t_request r;
        r = '{bg: 1'b0, dur: DUR_NONE, count: 4'd0, color: COL_BLACK};
        if (cmd == CMD_SEARCH) begin
            r.bg = 1'b1;
            if (srch) begin
                r.color = COL_BLUE;
                r.count = 4'd10;
                r.dur   = DUR_LONG;
            end
        end else begin
            case (peer)
                PEER_DISCONNECTED: r = '{1'b0, DUR_SHORT, 4'd2, COL_RED};
                PEER_CONNECTED:    r = '{1'b0, DUR_MEDIUM, 4'd2, COL_ORANGE};
                PEER_SECURED:      r = '{1'b0, DUR_MEDIUM, 4'd2, COL_GREEN};
                PEER_FAILED:       r = '{1'b0, DUR_MEDIUM, 4'd5, COL_RED};
                default:           ;  // black, zero blinks
            endcase
        end
        return r;
    endfunction

    function automatic t_led_beat shade_of(input t_color c);
        t_led_beat s;
        s = '0;
        case (c)
            COL_RED:    s.red = LVL_FULL;
            COL_GREEN:  s.green = LVL_FULL;
            COL_BLUE:   s.blue = LVL_FULL;
            COL_ORANGE: begin
                s.red   = LVL_FULL;
                s.green = LVL_ORANGE;
            end
            default:    ;
        endcase
        return s;
    endfunction

    // blink boundary: background runs and spent runs yield to the queue head
    function automatic void start_next_blink();
        t_request head;
        if ((run_left == 4'd0 || run_bg) && pending_requests.size() > 0) begin
            head     = pending_requests.pop_front();
            run_col  = head.color;
            run_left = head.count;
            run_cls  = head.dur;
            run_bg   = head.bg;
        end
        if (run_left != 4'd0) begin
            run_left  = run_left - 4'd1;
            led_phase = PH_ON;
            led_timer = on_time(run_cls);
        end else begin
            led_phase = PH_IDLE;
            led_timer = 16'd0;
        end
    endfunction

    function automatic void advance_tick();
        logic [15:0] half;
        case (led_phase)
            PH_ON: begin
                if (led_timer > 16'd1) begin
                    led_timer = led_timer - 16'd1;
                end else begin
                    // off time is half the current register, read live
                    half = on_time(run_cls) >> 1;
                    if (half != 16'd0) begin
                        led_phase = PH_OFF;
                        led_timer = half;
                    end else begin
                        start_next_blink();
                    end
                end
            end
            PH_OFF: begin
                if (led_timer > 16'd1) led_timer = led_timer - 16'd1;
                else start_next_blink();
            end
            default: start_next_blink();
        endcase
    endfunction

    // local beat word: [1:0] command, [4:2] peer_state, [5] search_active
    function automatic t_led_beat predict_beat(input logic [7:0] beat);
        t_led_beat res;
        logic      lost;
        lost = 1'b0;
        case (beat[1:0])
            CMD_TICK: advance_tick();
            CMD_PEER, CMD_SEARCH: begin
                if (pending_requests.size() >= LBRS_QUEUE_DEPTH) lost = 1'b1;
                else pending_requests.push_back(request_for(beat[1:0], beat[4:2], beat[5]));
            end
            default: ;
        endcase
        res         = shade_of(led_phase == PH_ON ? run_col : COL_BLACK);
        res.dropped = lost;
        return res;
    endfunction

    function automatic t_plan_row plan_row(input logic [1:0] cmd, input logic [2:0] peer,
                                           input logic srch, input bit typed,
                                           input t_led_beat want);
        t_plan_row r;
        r = '{cmd, peer, srch, typed, want};
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers (drive on falling edge, sample on rising edge)
    // ------------------------------------------------------------------
    task automatic send_beat(input logic [7:0] beat, input bit typed, input t_led_beat want);
        t_led_beat guess;
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= beat[1:0];
        i_s_tdata  <= {4'd0, beat[5:2]};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        guess = predict_beat(beat);
        if (guess.dropped) drops_predicted++;
        if (guess[23:0] != 24'd0) lit_predicted++;
        led_expected.push_back(typed ? want : guess);
        beats_sent++;
    endtask

    task automatic sender_gap(input int cycles);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // hold the input side until the DUT owes nothing
    task automatic settle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (led_expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_SHORT:  on_short  = val;
            REG_MEDIUM: on_medium = val;
            REG_LONG:   on_long   = val;
            default:    ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall bursts, then compare each beat
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (quiet) begin
            i_m_tready <= 1'b1;
        end else if (rx_hold > 0) begin
            i_m_tready <= 1'b0;
            rx_hold    <= rx_hold - 1;
        end else if ($urandom_range(0, 15) == 0) begin
            i_m_tready <= 1'b0;
            rx_hold    <= $urandom_range(0, 11);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : led_monitor
        t_led_beat got;
        t_led_beat want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[24:0];
            if (led_expected.size() == 0) begin
                $error("LED beat with nothing expected: tdata %h", o_m_tdata);
                fail_count++;
            end else begin
                want = led_expected.pop_front();
                beats_checked++;
                check_field("led_red", want.red, got.red);
                check_field("led_green", want.green, got.green);
                check_field("led_blue", want.blue, got.blue);
                check_field("request_dropped", want.dropped, got.dropped);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("led_blink_request_sequencer_top_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    // Per-phase on times, item counts and share of ticks. Phase 1 has a
    // zero short on time and a medium on time too short for an off phase;
    // phase 4 is drawn at random; the last one parks every class at max.
    int unsigned set_short  [PHASES] = '{3, 0, 2, 1, 0, 65535};
    int unsigned set_medium [PHASES] = '{5, 1, 4, 7, 0, 65535};
    int unsigned set_long   [PHASES] = '{8, 2, 6, 3, 0, 65535};
    int unsigned set_items  [PHASES] = '{120, 100, 100, 100, 90, 40};
    int unsigned set_ticks  [PHASES] = '{85, 60, 75, 45, 70, 50};

    initial begin
        t_plan_row  plan[$];
        logic [1:0] cmd;
        logic [2:0] peer;
        logic       srch;
        int unsigned pick;

        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = 8'd0;
        i_s_tuser  = CMD_TICK;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_SHORT;
        i_cfg_data = 16'd0;

        on_short  = SHORT_RESET;
        on_medium = MEDIUM_RESET;
        on_long   = LONG_RESET;
        led_phase = PH_IDLE;
        led_timer = 16'd0;
        run_left  = 4'd0;
        run_col   = COL_BLACK;
        run_cls   = DUR_SHORT;
        run_bg    = 1'b1;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at reset on times. Empty-queue tick, the no-op
        // command, zero-count requests consumed without a blink, a red
        // blink, then sixteen pushes fill the queue and one more is lost.
        plan.push_back(plan_row(CMD_TICK, PEER_DISCONNECTED, 1'b0, 1, LED_DARK));
        plan.push_back(plan_row(CMD_UNUSED, PEER_OTHER, 1'b1, 1, LED_DARK));
        plan.push_back(plan_row(CMD_PEER, PEER_OTHER, 1'b0, 1, LED_DARK));
        plan.push_back(plan_row(CMD_TICK, PEER_DISCONNECTED, 1'b0, 1, LED_DARK));
        plan.push_back(plan_row(CMD_SEARCH, PEER_DISCONNECTED, 1'b0, 1, LED_DARK));
        plan.push_back(plan_row(CMD_TICK, PEER_FAILED, 1'b1, 1, LED_DARK));
        plan.push_back(plan_row(CMD_PEER, PEER_DISCONNECTED, 1'b0, 1, LED_DARK));
        plan.push_back(plan_row(CMD_TICK, PEER_DISCONNECTED, 1'b0, 1, LED_RED_ON));
        plan.push_back(plan_row(CMD_PEER, PEER_CONNECTED, 1'b0, 0, LED_DARK));
        plan.push_back(plan_row(CMD_PEER, PEER_SECURED, 1'b1, 0, LED_DARK));
        plan.push_back(plan_row(CMD_PEER, PEER_FAILED, 1'b0, 0, LED_DARK));
        plan.push_back(plan_row(CMD_PEER, PEER_OTHER, 1'b1, 0, LED_DARK));
        plan.push_back(plan_row(CMD_PEER, PEER_DISCONNECTED, 1'b0, 0, LED_DARK));
        plan.push_back(plan_row(CMD_SEARCH, PEER_OTHER, 1'b1, 0, LED_DARK));
        plan.push_back(plan_row(CMD_SEARCH, PEER_FAILED, 1'b0, 0, LED_DARK));
        plan.push_back(plan_row(CMD_PEER, PEER_CONNECTED, 1'b1, 0, LED_DARK));
        plan.push_back(plan_row(CMD_PEER, PEER_FAILED, 1'b0, 0, LED_DARK));
        plan.push_back(plan_row(CMD_PEER, PEER_SECURED, 1'b0, 0, LED_DARK));
        plan.push_back(plan_row(CMD_SEARCH, PEER_DISCONNECTED, 1'b1, 0, LED_DARK));
        plan.push_back(plan_row(CMD_PEER, PEER_OTHER, 1'b0, 0, LED_DARK));
        plan.push_back(plan_row(CMD_PEER, PEER_DISCONNECTED, 1'b1, 0, LED_DARK));
        plan.push_back(plan_row(CMD_PEER, PEER_CONNECTED, 1'b0, 0, LED_DARK));
        plan.push_back(plan_row(CMD_SEARCH, PEER_SECURED, 1'b1, 0, LED_DARK));
        plan.push_back(plan_row(CMD_PEER, PEER_FAILED, 1'b1, 0, LED_DARK));
        plan.push_back(plan_row(CMD_SEARCH, PEER_CONNECTED, 1'b1, 1, LED_RED_DROP));

        foreach (plan[k])
            send_beat({2'b00, plan[k].srch, plan[k].peer, plan[k].cmd},
                      plan[k].typed, plan[k].want);
        settle();

        // Random phases. Registers change only with nothing in flight.
        set_short[4]  = $urandom_range(0, 12);
        set_medium[4] = $urandom_range(0, 12);
        set_long[4]   = $urandom_range(0, 12);
        for (int ph = 0; ph < PHASES; ph++) begin
            quiet = (ph == PHASES - 1);
            write_reg(REG_SHORT, 16'(set_short[ph]));
            write_reg(REG_MEDIUM, 16'(set_medium[ph]));
            write_reg(REG_LONG, 16'(set_long[ph]));
            for (int n = 0; n < set_items[ph]; n++) begin
                if (ph == 2 && n == set_items[ph] / 2) settle();
                if (!quiet && $urandom_range(0, 9) == 0) sender_gap($urandom_range(1, 12));
                // unused fields of ticks carry noise; peer states lean to
                // the four that map to real blinks
                peer = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                   : 3'($urandom_range(0, 3));
                srch = 1'($urandom_range(0, 1));
                pick = $urandom_range(0, 19);
                if ($urandom_range(0, 99) < set_ticks[ph]) cmd = CMD_TICK;
                else if (pick == 0)                        cmd = CMD_UNUSED;
                else if (pick <= 10)                       cmd = CMD_PEER;
                else                                       cmd = CMD_SEARCH;
                send_beat({2'b00, srch, peer, cmd}, 0, LED_DARK);
            end
            settle();
        end

        repeat (10) @(posedge i_clk);

        $display("Sent %0d beats over %0d on-time settings, checked %0d LED beats.",
                 beats_sent, PHASES + 1, beats_checked);
        $display("Predicted %0d lit beats and %0d requests lost to a full queue.",
                 lit_predicted, drops_predicted);
        if (fail_count == 0 && led_expected.size() == 0) begin
            $display("led_blink_request_sequencer_top_tb: clean");
        end else begin
            $display("led_blink_request_sequencer_top_tb: errors");
        end
        $finish;
    end

endmodule
